// ===== rtl/jdqw_pkg.sv =====
package jdqw_pkg;

  // Field widths of the channels
  localparam int REQ_W     = 2;
  localparam int WIDX_W    = 4;
  localparam int WGT_W     = 31;
  localparam int JAC_W     = 32;
  localparam int MASS_W    = 64;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  // Default grid limit and register reset value
  localparam int          MAX_POINTS_DEF = 16;
  localparam logic [4:0]  POINTS_RESET   = 5'd16;

  // Arithmetic sizes: one shared 33x33 signed multiplier, 192-bit accumulator
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 192;
  localparam int FRAC_SHIFT = 106;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_JAC    = 2'd0,
    REQ_LOAD_U = 2'd1,
    REQ_LOAD_V = 2'd2,
    REQ_LOAD_W = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_U = 2'd0,
    REG_POINTS_V = 2'd1,
    REG_POINTS_W = 2'd2
  } reg_idx_t;

  // One queued grid point: Jacobian, its three weights and its tags
  typedef struct packed {
    logic [8:0][JAC_W-1:0] jac;
    logic [WGT_W-1:0]      wu;
    logic [WGT_W-1:0]      wv;
    logic [WGT_W-1:0]      ww;
    logic [IDX_W-1:0]      point_index;
    logic                  last_point;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/jdqw_if.sv =====
interface jdqw_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [3:0]               weight_index;
  logic [30:0]              weight_value;
  logic signed [31:0]       jac_00;
  logic signed [31:0]       jac_01;
  logic signed [31:0]       jac_02;
  logic signed [31:0]       jac_10;
  logic signed [31:0]       jac_11;
  logic signed [31:0]       jac_12;
  logic signed [31:0]       jac_20;
  logic signed [31:0]       jac_21;
  logic signed [31:0]       jac_22;

  modport source (
    output valid, req_type, weight_index, weight_value,
    output jac_00, jac_01, jac_02, jac_10, jac_11, jac_12, jac_20, jac_21, jac_22,
    input  ready
  );
  modport sink (
    input  valid, req_type, weight_index, weight_value,
    input  jac_00, jac_01, jac_02, jac_10, jac_11, jac_12, jac_20, jac_21, jac_22,
    output ready
  );
endinterface

interface jdqw_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] mass_weight;
  logic [11:0]        point_index;
  logic               last_point;

  modport source (output valid, mass_weight, point_index, last_point, input ready);
  modport sink   (input valid, mass_weight, point_index, last_point, output ready);
endinterface

interface jdqw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/jdqw_front.sv =====
module jdqw_front
  import jdqw_pkg::*;
#(
  parameter int MAX_POINTS_PER_DIR = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  jdqw_in_if.sink      in_ch,
  jdqw_cfg_if.sink     cfg_ch,
  input  q_stat_t      q_stat,
  output logic         push,
  output job_t         push_job
);

  localparam int PW = (MAX_POINTS_PER_DIR > 1) ? $clog2(MAX_POINTS_PER_DIR) : 1;
  localparam int CW = $clog2(MAX_POINTS_PER_DIR + 1);

  logic [CFG_W-1:0] pts_u_r, pts_v_r, pts_w_r;
  logic [PW-1:0]    pos_u_r, pos_v_r, pos_w_r;
  logic [CW-1:0]    nu, nv, nw;
  logic             last_u, last_v, last_w;
  logic [IDX_W-1:0] t_vw, t_v, t_uv, lin_idx;
  logic             in_xfer, is_jac, cfg_xfer, cfg_hit, widx_ok;
  logic [PW-1:0]    widx;
  logic             stg_vld_r;
  job_t             stg_job_r;

  // Weight tables, undefined until loaded
  logic [WGT_W-1:0] tbl_u_r [MAX_POINTS_PER_DIR];
  logic [WGT_W-1:0] tbl_v_r [MAX_POINTS_PER_DIR];
  logic [WGT_W-1:0] tbl_w_r [MAX_POINTS_PER_DIR];

  // Register value 0 counts as 1, values above the limit clamp to it
  function automatic logic [CW-1:0] eff(input logic [CFG_W-1:0] n);
    if (n == '0) begin
      return CW'(1);
    end else if (32'(n) > MAX_POINTS_PER_DIR) begin
      return CW'(MAX_POINTS_PER_DIR);
    end else begin
      return CW'(n);
    end
  endfunction

  assign nu = eff(pts_u_r);
  assign nv = eff(pts_v_r);
  assign nw = eff(pts_w_r);

  assign last_u = (32'(pos_u_r) + 32'd1) == 32'(nu);
  assign last_v = (32'(pos_v_r) + 32'd1) == 32'(nv);
  assign last_w = (32'(pos_w_r) + 32'd1) == 32'(nw);

  // Linear index u + nu*(v + nv*w), kept modulo 4096
  assign t_vw    = IDX_W'(nv) * IDX_W'(pos_w_r);
  assign t_v     = t_vw + IDX_W'(pos_v_r);
  assign t_uv    = IDX_W'(nu) * t_v;
  assign lin_idx = t_uv + IDX_W'(pos_u_r);

  // Handshakes and classification
  assign in_ch.ready  = !stg_vld_r || !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign is_jac       = req_type_t'(in_ch.req_type) == REQ_JAC;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit      = cfg_xfer && (cfg_ch.index == REG_POINTS_U ||
                                     cfg_ch.index == REG_POINTS_V ||
                                     cfg_ch.index == REG_POINTS_W);
  assign widx_ok      = 32'(in_ch.weight_index) < MAX_POINTS_PER_DIR;
  assign widx         = PW'(in_ch.weight_index);

  assign push     = stg_vld_r && !q_stat.full;
  assign push_job = stg_job_r;

  // Control: grid size, grid position, stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_u_r   <= POINTS_RESET;
      pts_v_r   <= POINTS_RESET;
      pts_w_r   <= POINTS_RESET;
      pos_u_r   <= '0;
      pos_v_r   <= '0;
      pos_w_r   <= '0;
      stg_vld_r <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (cfg_ch.index)
          REG_POINTS_U: pts_u_r <= cfg_ch.data;
          REG_POINTS_V: pts_v_r <= cfg_ch.data;
          REG_POINTS_W: pts_w_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        pos_u_r <= '0;
        pos_v_r <= '0;
        pos_w_r <= '0;
      end else if (in_xfer && is_jac) begin
        if (last_u) begin
          pos_u_r <= '0;
          if (last_v) begin
            pos_v_r <= '0;
            pos_w_r <= last_w ? '0 : pos_w_r + PW'(1);
          end else begin
            pos_v_r <= pos_v_r + PW'(1);
          end
        end else begin
          pos_u_r <= pos_u_r + PW'(1);
        end
      end
      if (in_xfer && is_jac) begin
        stg_vld_r <= 1'b1;
      end else if (push) begin
        stg_vld_r <= 1'b0;
      end
    end
  end

  // Payload: table writes and the stage register with registered table reads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      unique case (req_type_t'(in_ch.req_type))
        REQ_JAC: begin
          stg_job_r.jac <= {in_ch.jac_22, in_ch.jac_21, in_ch.jac_20,
                            in_ch.jac_12, in_ch.jac_11, in_ch.jac_10,
                            in_ch.jac_02, in_ch.jac_01, in_ch.jac_00};
          stg_job_r.wu          <= tbl_u_r[pos_u_r];
          stg_job_r.wv          <= tbl_v_r[pos_v_r];
          stg_job_r.ww          <= tbl_w_r[pos_w_r];
          stg_job_r.point_index <= lin_idx;
          stg_job_r.last_point  <= last_u && last_v && last_w;
        end
        REQ_LOAD_U: if (widx_ok) tbl_u_r[widx] <= in_ch.weight_value;
        REQ_LOAD_V: if (widx_ok) tbl_v_r[widx] <= in_ch.weight_value;
        REQ_LOAD_W: if (widx_ok) tbl_w_r[widx] <= in_ch.weight_value;
      endcase
    end
  end

endmodule

// ===== rtl/jdqw_fifo.sv =====
module jdqw_fifo
  import jdqw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop_job      = ent_r[rd_ptr_r];
  assign q_stat.full  = 32'(cnt_r) == QUEUE_DEPTH;
  assign q_stat.empty = cnt_r == '0;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== rtl/jdqw_back.sv =====
module jdqw_back
  import jdqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  job_t        pop_job,
  output logic        pop,
  jdqw_out_if.source  out_ch
);

  localparam int SH_W      = 7;
  localparam int LAST_STEP = 25;
  localparam int STEP_W    = $clog2(LAST_STEP + 1);
  localparam int M_W       = 65;
  localparam int DET_W     = 97;
  localparam int WUV_W     = 62;
  localparam int WT_W      = 93;
  localparam int SAT_LO    = FRAC_SHIFT + MASS_W - 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  typedef enum logic [3:0] {
    A_J00, A_J01, A_J02, A_J10, A_J11, A_J12, A_J20,
    A_WU, A_WUV_LO, A_WUV_HI, A_DET0, A_DET1, A_DET2
  } a_sel_t;

  typedef enum logic [3:0] {
    B_J11, B_J12, B_J21, B_J22, B_WV, B_WW,
    B_M0_LO, B_M0_HI, B_M1_LO, B_M1_HI, B_M2_LO, B_M2_HI,
    B_WT0, B_WT1, B_WT2
  } b_sel_t;

  typedef enum logic [2:0] {D_NONE, D_M0, D_M1, D_M2, D_WUV, D_DET, D_WT} dst_t;

  typedef struct packed {
    logic            vld;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    logic            neg;
    logic            clr;
    logic [SH_W-1:0] sh;
    dst_t            dst;
  } op_t;

  function automatic op_t mk(input a_sel_t a, input b_sel_t b, input logic neg,
                             input logic clr, input int sh, input dst_t d);
    op_t o;
    o.vld   = 1'b1;
    o.a_sel = a;
    o.b_sel = b;
    o.neg   = neg;
    o.clr   = clr;
    o.sh    = SH_W'(sh);
    o.dst   = d;
    return o;
  endfunction

  // Micro-op sequence: minors, wu*wv, determinant, wu*wv*ww, final product.
  // A bubble sits where an operand is the result of the op just before.
  function automatic op_t op_at(input logic [STEP_W-1:0] s);
    op_t o;
    o = op_t'('0);
    unique case (s)
      0:  o = mk(A_J11,    B_J22,   1'b0, 1'b1, 0,   D_NONE);
      1:  o = mk(A_J12,    B_J21,   1'b1, 1'b0, 0,   D_M0);
      2:  o = mk(A_J01,    B_J22,   1'b0, 1'b1, 0,   D_NONE);
      3:  o = mk(A_J02,    B_J21,   1'b1, 1'b0, 0,   D_M1);
      4:  o = mk(A_J01,    B_J12,   1'b0, 1'b1, 0,   D_NONE);
      5:  o = mk(A_J02,    B_J11,   1'b1, 1'b0, 0,   D_M2);
      6:  o = mk(A_WU,     B_WV,    1'b0, 1'b1, 0,   D_WUV);
      7:  o = mk(A_J00,    B_M0_LO, 1'b0, 1'b1, 0,   D_NONE);
      8:  o = mk(A_J00,    B_M0_HI, 1'b0, 1'b0, 32,  D_NONE);
      9:  o = mk(A_J10,    B_M1_LO, 1'b1, 1'b0, 0,   D_NONE);
      10: o = mk(A_J10,    B_M1_HI, 1'b1, 1'b0, 32,  D_NONE);
      11: o = mk(A_J20,    B_M2_LO, 1'b0, 1'b0, 0,   D_NONE);
      12: o = mk(A_J20,    B_M2_HI, 1'b0, 1'b0, 32,  D_DET);
      13: o = mk(A_WUV_LO, B_WW,    1'b0, 1'b1, 0,   D_NONE);
      14: o = mk(A_WUV_HI, B_WW,    1'b0, 1'b0, 31,  D_WT);
      16: o = mk(A_DET0,   B_WT0,   1'b0, 1'b1, 0,   D_NONE);
      17: o = mk(A_DET0,   B_WT1,   1'b0, 1'b0, 31,  D_NONE);
      18: o = mk(A_DET0,   B_WT2,   1'b0, 1'b0, 62,  D_NONE);
      19: o = mk(A_DET1,   B_WT0,   1'b0, 1'b0, 32,  D_NONE);
      20: o = mk(A_DET1,   B_WT1,   1'b0, 1'b0, 63,  D_NONE);
      21: o = mk(A_DET1,   B_WT2,   1'b0, 1'b0, 94,  D_NONE);
      22: o = mk(A_DET2,   B_WT0,   1'b0, 1'b0, 64,  D_NONE);
      23: o = mk(A_DET2,   B_WT1,   1'b0, 1'b0, 95,  D_NONE);
      24: o = mk(A_DET2,   B_WT2,   1'b0, 1'b0, 126, D_NONE);
      default: o = op_t'('0);
    endcase
    return o;
  endfunction

  state_t                    state_r;
  logic [STEP_W-1:0]         step_r;
  job_t                      job_r;
  op_t                       op, pop_r;
  logic                      issue, pvld_r;
  logic signed [MUL_W-1:0]   a_op, b_op;
  logic signed [PROD_W-1:0]  prod, p_r;
  logic [ACC_W-1:0]          p_ext, p_sh, term, acc_base, acc_sum, acc_r;
  logic [M_W-1:0]            m0_r, m1_r, m2_r;
  logic [DET_W-1:0]          det_r;
  logic [WUV_W-1:0]          wuv_r;
  logic [WT_W-1:0]           wt_r;
  logic                      out_valid_r, out_last_r, out_free, sat_ok;
  logic [MASS_W-1:0]         out_mass_r, sat_val;
  logic [IDX_W-1:0]          out_idx_r;

  function automatic logic [MUL_W-1:0] sx(input logic [JAC_W-1:0] v);
    return {v[JAC_W-1], v};
  endfunction

  assign op    = op_at(step_r);
  assign issue = (state_r == S_RUN) && op.vld;
  assign pop   = (state_r == S_IDLE) && !q_stat.empty;

  // Operand A select
  always_comb begin
    unique case (op.a_sel)
      A_J00:    a_op = sx(job_r.jac[0]);
      A_J01:    a_op = sx(job_r.jac[1]);
      A_J02:    a_op = sx(job_r.jac[2]);
      A_J10:    a_op = sx(job_r.jac[3]);
      A_J11:    a_op = sx(job_r.jac[4]);
      A_J12:    a_op = sx(job_r.jac[5]);
      A_J20:    a_op = sx(job_r.jac[6]);
      A_WU:     a_op = {2'b00, job_r.wu};
      A_WUV_LO: a_op = {2'b00, wuv_r[30:0]};
      A_WUV_HI: a_op = {2'b00, wuv_r[61:31]};
      A_DET0:   a_op = {1'b0, det_r[31:0]};
      A_DET1:   a_op = {1'b0, det_r[63:32]};
      A_DET2:   a_op = det_r[96:64];
      default:  a_op = '0;
    endcase
  end

  // Operand B select
  always_comb begin
    unique case (op.b_sel)
      B_J11:   b_op = sx(job_r.jac[4]);
      B_J12:   b_op = sx(job_r.jac[5]);
      B_J21:   b_op = sx(job_r.jac[7]);
      B_J22:   b_op = sx(job_r.jac[8]);
      B_WV:    b_op = {2'b00, job_r.wv};
      B_WW:    b_op = {2'b00, job_r.ww};
      B_M0_LO: b_op = {1'b0, m0_r[31:0]};
      B_M0_HI: b_op = m0_r[64:32];
      B_M1_LO: b_op = {1'b0, m1_r[31:0]};
      B_M1_HI: b_op = m1_r[64:32];
      B_M2_LO: b_op = {1'b0, m2_r[31:0]};
      B_M2_HI: b_op = m2_r[64:32];
      B_WT0:   b_op = {2'b00, wt_r[30:0]};
      B_WT1:   b_op = {2'b00, wt_r[61:31]};
      B_WT2:   b_op = {2'b00, wt_r[92:62]};
      default: b_op = '0;
    endcase
  end

  assign prod = a_op * b_op;

  // Accumulate the registered product at its limb offset
  assign p_ext    = {{(ACC_W - PROD_W){p_r[PROD_W-1]}}, p_r};
  assign p_sh     = p_ext << pop_r.sh;
  assign term     = pop_r.neg ? (~p_sh) + ACC_W'(1) : p_sh;
  assign acc_base = pop_r.clr ? '0 : acc_r;
  assign acc_sum  = acc_base + term;

  // Floor shift by the fraction width, then clamp to 64 bits
  assign sat_ok  = acc_r[ACC_W-1:SAT_LO] == {(ACC_W - SAT_LO){acc_r[ACC_W-1]}};
  assign sat_val = sat_ok ? acc_r[SAT_LO:FRAC_SHIFT]
                 : (acc_r[ACC_W-1] ? {1'b1, {(MASS_W - 1){1'b0}}}
                                   : {1'b0, {(MASS_W - 1){1'b1}}});

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result in S_DONE takes the place of the one leaving
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          step_r <= step_r + STEP_W'(1);
          if (32'(step_r) == LAST_STEP) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_mass_r  <= sat_val;
            out_idx_r   <= job_r.point_index;
            out_last_r  <= job_r.last_point;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Multiplier pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= issue;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) job_r <= pop_job;
    if (issue) begin
      p_r   <= prod;
      pop_r <= op;
    end
    if (pvld_r) begin
      acc_r <= acc_sum;
      case (pop_r.dst)
        D_M0:    m0_r  <= acc_sum[M_W-1:0];
        D_M1:    m1_r  <= acc_sum[M_W-1:0];
        D_M2:    m2_r  <= acc_sum[M_W-1:0];
        D_WUV:   wuv_r <= acc_sum[WUV_W-1:0];
        D_DET:   det_r <= acc_sum[DET_W-1:0];
        D_WT:    wt_r  <= acc_sum[WT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mass_weight = out_mass_r;
  assign out_ch.point_index = out_idx_r;
  assign out_ch.last_point  = out_last_r;

endmodule

// ===== rtl/jacobian_det_quadrature_weight_core.sv =====
// Quadrature mass weight per grid point. Weight-load transfers (req_type 1..3)
// fill the u, v and w weight tables, one entry per transfer, and give no result;
// every entry a point uses must have been loaded beforehand. Jacobian
// transfers (req_type 0) walk the grid u-fastest; the front end reads the
// point's three weights and queues the point, and the back end forms
// det(J) * wu * wv * ww as a signed Q32.32 value, floored and saturated to
// 64 bits, with the linear point index and a last-point flag. The back end
// runs every product through one shared 33x33 signed multiplier (24 products
// over a 26-step sequence) and takes one point at a time; the front end keeps
// accepting points and weight loads while the back end is busy, until its
// stage register and the two-entry queue are full.
// Writing any of the three grid-size registers restarts the grid at point 0.
module jacobian_det_quadrature_weight_core
  import jdqw_pkg::*;
#(
  parameter int MAX_POINTS_PER_DIR = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jdqw_in_if.sink     in_ch,
  jdqw_out_if.source  out_ch,
  jdqw_cfg_if.sink    cfg_ch
);

  logic    push, pop;
  job_t    push_job, pop_job;
  q_stat_t q_stat;

  // Accept, classify, look up weights
  jdqw_front #(
    .MAX_POINTS_PER_DIR(MAX_POINTS_PER_DIR)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Queue between front and back end
  jdqw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // Determinant and weight product
  jdqw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // Queue never overrun or underrun
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

// ===== verif/tb_top.sv =====
module tb_top
  import jdqw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEMS         = 550;
  localparam int          WIDE_W        = 200;  // holds det times weights exactly
  localparam int          SETTLE_CYCLES = 40;   // idle wait at the end of each drain
  localparam int          LONG_HOLD     = 400;
  localparam int          IDLE_LIMIT    = 4000;
  localparam logic [30:0] WEIGHT_MAX    = 31'h7FFF_FFFF;
  localparam logic [30:0] WEIGHT_ONE    = 31'h4000_0000;
  localparam logic [31:0] JAC_ONE       = 32'h0001_0000;
  localparam logic [31:0] JAC_MIN       = 32'h8000_0000;
  localparam logic [31:0] JAC_MAX       = 32'h7FFF_FFFF;

  // One input transfer and one result transfer
  typedef struct packed {
    req_type_t             kind;
    logic [WIDX_W-1:0]     widx;
    logic [WGT_W-1:0]      wval;
    logic [8:0][JAC_W-1:0] jac;
  } grid_req_t;

  typedef struct packed {
    logic signed [MASS_W-1:0] mass;
    logic [IDX_W-1:0]         index;
    logic                     last;
  } mass_result_t;

  // Predicts the mass weight of each grid point and checks what comes out
  class mass_weight_scoreboard;
    logic [WGT_W-1:0] wtab_u [MAX_POINTS_DEF];
    logic [WGT_W-1:0] wtab_v [MAX_POINTS_DEF];
    logic [WGT_W-1:0] wtab_w [MAX_POINTS_DEF];
    bit               loaded_u [MAX_POINTS_DEF];
    bit               loaded_v [MAX_POINTS_DEF];
    bit               loaded_w [MAX_POINTS_DEF];
    logic [CFG_W-1:0] size_u, size_v, size_w;
    int unsigned      pos_u, pos_v, pos_w;
    mass_result_t     awaited [$];
    int unsigned      errors;

    function new();
      size_u = POINTS_RESET;
      size_v = POINTS_RESET;
      size_w = POINTS_RESET;
      pos_u  = 0;
      pos_v  = 0;
      pos_w  = 0;
      errors = 0;
      foreach (loaded_u[i]) begin
        loaded_u[i] = 1'b0;
        loaded_v[i] = 1'b0;
        loaded_w[i] = 1'b0;
      end
    endfunction

    // 0 behaves as 1, anything above the table depth as the depth
    function int unsigned grid_extent(logic [CFG_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_POINTS_DEF) return MAX_POINTS_DEF;
      return 32'(n);
    endfunction

    function void write_reg(reg_idx_t r, logic [CFG_W-1:0] d);
      case (r)
        REG_POINTS_U: size_u = d;
        REG_POINTS_V: size_v = d;
        REG_POINTS_W: size_w = d;
        default: return;
      endcase
      pos_u = 0;
      pos_v = 0;
      pos_w = 0;
    endfunction

    // Exact det(J) * wu * wv * ww, floored from Q62.138 down to Q32.32
    function logic signed [MASS_W-1:0] weighted_det(logic [8:0][JAC_W-1:0] jac,
                                                     logic [WGT_W-1:0] wu,
                                                     logic [WGT_W-1:0] wv,
                                                     logic [WGT_W-1:0] ww);
      logic signed [WIDE_W-1:0] e [9];
      logic signed [WIDE_W-1:0] a, b, c, det, wprod, scaled;
      int i;
      for (i = 0; i < 9; i++) e[i] = $signed(jac[i]);
      // expansion down the first column, true sign on the middle cofactor
      det = e[0] * (e[4] * e[8] - e[5] * e[7])
          - e[3] * (e[1] * e[8] - e[2] * e[7])
          + e[6] * (e[1] * e[5] - e[2] * e[4]);
      a = wu;
      b = wv;
      c = ww;
      wprod  = a * b * c;
      scaled = (det * wprod) >>> FRAC_SHIFT;
      if (&scaled[WIDE_W-1:MASS_W-1] || ~|scaled[WIDE_W-1:MASS_W-1])
        return scaled[MASS_W-1:0];
      return scaled[WIDE_W-1] ? {1'b1, {(MASS_W-1){1'b0}}} : {1'b0, {(MASS_W-1){1'b1}}};
    endfunction

    function void note_input(grid_req_t it);
      int unsigned  nu, nv, nw;
      mass_result_t r;
      nu = grid_extent(size_u);
      nv = grid_extent(size_v);
      nw = grid_extent(size_w);
      case (it.kind)
        REQ_LOAD_U: begin
          wtab_u[it.widx]   = it.wval;
          loaded_u[it.widx] = 1'b1;
        end
        REQ_LOAD_V: begin
          wtab_v[it.widx]   = it.wval;
          loaded_v[it.widx] = 1'b1;
        end
        REQ_LOAD_W: begin
          wtab_w[it.widx]   = it.wval;
          loaded_w[it.widx] = 1'b1;
        end
        REQ_JAC: begin
          r.mass  = weighted_det(it.jac, wtab_u[pos_u], wtab_v[pos_v], wtab_w[pos_w]);
          r.index = IDX_W'(pos_u + nu * pos_v + nu * nv * pos_w);
          r.last  = (pos_u == nu - 1) && (pos_v == nv - 1) && (pos_w == nw - 1);
          awaited.push_back(r);
          // u fastest, wrap to point 0 after the last one
          pos_u++;
          if (pos_u >= nu) begin
            pos_u = 0;
            pos_v++;
            if (pos_v >= nv) begin
              pos_v = 0;
              pos_w++;
              if (pos_w >= nw) pos_w = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(mass_result_t got);
      mass_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, index %0d mass %0d", $time, got.index, got.mass);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.mass !== want.mass) begin
        $display("%0t: mass_weight expected %0d, got %0d", $time, want.mass, got.mass);
        errors++;
      end
      if (got.index !== want.index) begin
        $display("%0t: point_index expected %0d, got %0d", $time, want.index, got.index);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_point expected %0b, got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function void flag_leftover();
      if (awaited.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, awaited.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  jdqw_in_if  in_bus ();
  jdqw_out_if out_bus ();
  jdqw_cfg_if cfg_bus ();

  jacobian_det_quadrature_weight_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  mass_weight_scoreboard sb = new();

  bit sender_eager   = 1'b0;
  bit receiver_eager = 1'b0;
  bit long_hold_req  = 1'b0;
  int n_sent         = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random hold after each transfer, one long hold on request
  initial begin : receiver
    int           hold;
    mass_result_t got;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.mass  = out_bus.mass_weight;
        got.index = out_bus.point_index;
        got.last  = out_bus.last_point;
        sb.check_result(got);
        if (long_hold_req) begin
          hold          = LONG_HOLD;
          long_hold_req = 1'b0;
        end else begin
          hold = receiver_eager ? 0 : $urandom_range(0, 5);
        end
      end else if (hold > 0) begin
        hold--;
      end
      out_bus.ready <= (hold == 0);
    end
  end

  // Watchdog: too long without any transfer on any channel
  initial begin : watchdog
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [8:0][JAC_W-1:0] matrix3(
    logic [31:0] j00, logic [31:0] j01, logic [31:0] j02,
    logic [31:0] j10, logic [31:0] j11, logic [31:0] j12,
    logic [31:0] j20, logic [31:0] j21, logic [31:0] j22);
    return {j22, j21, j20, j12, j11, j10, j02, j01, j00};
  endfunction

  // Scale 0 stays near unity, 2 spans the full range, 3 mixes in extremes
  function automatic logic [JAC_W-1:0] draw_entry(int unsigned scale);
    logic signed [JAC_W-1:0] raw;
    raw = $urandom;
    case (scale)
      0: return raw >>> 13;
      1: return raw >>> 6;
      2: return raw;
      default: begin
        case ($urandom_range(0, 4))
          0: return JAC_MIN;
          1: return JAC_MAX;
          2: return '0;
          3: return '1;
          default: return raw;
        endcase
      end
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] draw_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WEIGHT_MAX;
      2, 3: return WGT_W'($urandom_range(0, 32'h4000_0000));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_extent();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(17, 31));
    if (r == 2) return CFG_W'(16);
    if (r <= 6) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // Offers one item after a random gap and returns once it has transferred
  task automatic drive_in(grid_req_t it);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.req_type     <= it.kind;
    in_bus.weight_index <= it.widx;
    in_bus.weight_value <= it.wval;
    in_bus.jac_00       <= it.jac[0];
    in_bus.jac_01       <= it.jac[1];
    in_bus.jac_02       <= it.jac[2];
    in_bus.jac_10       <= it.jac[3];
    in_bus.jac_11       <= it.jac[4];
    in_bus.jac_12       <= it.jac[5];
    in_bus.jac_20       <= it.jac[6];
    in_bus.jac_21       <= it.jac[7];
    in_bus.jac_22       <= it.jac[8];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_input(it);
    n_sent++;
  endtask

  task automatic send_load(req_type_t kind, logic [WIDX_W-1:0] idx, logic [WGT_W-1:0] val);
    grid_req_t it;
    int        k;
    it.kind = kind;
    it.widx = idx;
    it.wval = val;
    for (k = 0; k < 9; k++) it.jac[k] = $urandom;  // ignored on loads
    drive_in(it);
  endtask

  // Loads any weight the next point needs that was never written, then the point
  task automatic send_point(logic [8:0][JAC_W-1:0] jac);
    grid_req_t it;
    if (!sb.loaded_u[sb.pos_u]) send_load(REQ_LOAD_U, WIDX_W'(sb.pos_u), draw_weight());
    if (!sb.loaded_v[sb.pos_v]) send_load(REQ_LOAD_V, WIDX_W'(sb.pos_v), draw_weight());
    if (!sb.loaded_w[sb.pos_w]) send_load(REQ_LOAD_W, WIDX_W'(sb.pos_w), draw_weight());
    it.kind = REQ_JAC;
    it.widx = WIDX_W'($urandom);
    it.wval = WGT_W'($urandom);
    it.jac  = jac;
    drive_in(it);
  endtask

  task automatic send_random_point();
    logic [8:0][JAC_W-1:0] jac;
    int unsigned           r, scale;
    int                    k;
    r     = $urandom_range(0, 4);
    scale = (r < 2) ? 0 : r - 1;
    for (k = 0; k < 9; k++) jac[k] = draw_entry(scale);
    send_point(jac);
  endtask

  task automatic send_random_load();
    req_type_t kind;
    case ($urandom_range(0, 2))
      0: kind = REQ_LOAD_U;
      1: kind = REQ_LOAD_V;
      default: kind = REQ_LOAD_W;
    endcase
    send_load(kind, WIDX_W'($urandom), draw_weight());
  endtask

  // Stop offering, wait for every outstanding result, let the back end settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [CFG_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= r;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(r, d);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] nu, logic [CFG_W-1:0] nv,
                            logic [CFG_W-1:0] nw);
    write_reg(REG_POINTS_U, nu);
    write_reg(REG_POINTS_V, nv);
    write_reg(REG_POINTS_W, nw);
  endtask

  initial begin : stimulus
    int          phase_len, k;
    int unsigned mask;
    bit          held_once;

    held_once = 1'b0;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.req_type     <= REQ_JAC;
    in_bus.weight_index <= '0;
    in_bus.weight_value <= '0;
    in_bus.jac_00       <= '0;
    in_bus.jac_01       <= '0;
    in_bus.jac_02       <= '0;
    in_bus.jac_10       <= '0;
    in_bus.jac_11       <= '0;
    in_bus.jac_12       <= '0;
    in_bus.jac_20       <= '0;
    in_bus.jac_21       <= '0;
    in_bus.jac_22       <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_POINTS_U;
    cfg_bus.data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting on the reset grid size
    send_load(REQ_LOAD_U, 4'd0, WEIGHT_MAX);
    send_load(REQ_LOAD_V, 4'd0, WEIGHT_MAX);
    send_load(REQ_LOAD_W, 4'd0, WEIGHT_MAX);
    // most negative diagonal with largest weights: saturates low
    send_point(matrix3(JAC_MIN, '0, '0, '0, JAC_MIN, '0, '0, '0, JAC_MIN));
    // most positive diagonal: saturates high
    send_load(REQ_LOAD_U, 4'd1, WEIGHT_ONE);
    send_point(matrix3(JAC_MAX, '0, '0, '0, JAC_MAX, '0, '0, '0, JAC_MAX));
    // row swap: only the middle cofactor contributes, exactly -1.0
    send_load(REQ_LOAD_U, 4'd2, WEIGHT_ONE);
    send_load(REQ_LOAD_V, 4'd0, WEIGHT_ONE);
    send_load(REQ_LOAD_W, 4'd0, WEIGHT_ONE);
    send_point(matrix3('0, JAC_ONE, '0, JAC_ONE, '0, '0, '0, '0, JAC_ONE));
    // zero weight kills any determinant
    send_load(REQ_LOAD_U, 4'd3, '0);
    send_point(matrix3(JAC_MAX, JAC_MIN, '1, JAC_MIN, JAC_MAX, '1, '1, JAC_MIN, JAC_MAX));
    // tiny negative determinant floors to -1 lsb
    send_load(REQ_LOAD_U, 4'd4, WEIGHT_ONE);
    send_point(matrix3(32'd1, '0, '0, '0, 32'd1, '0, '0, '0, '1));
    send_point('0);
    drain();
    // single-point grid: every point is the last
    write_grid(5'd1, 5'd1, 5'd1);
    send_random_point();
    send_random_point();
    drain();
    // zero size acts as one, oversize as the table depth
    write_grid(5'd0, 5'd0, 5'd0);
    send_random_point();
    drain();
    write_grid(5'd31, 5'd31, 5'd31);
    send_random_point();

    // Random phases, each on a fresh grid size
    while (n_sent < ITEMS) begin
      drain();
      mask = $urandom_range(1, 7);
      if (mask[0]) write_reg(REG_POINTS_U, draw_extent());
      if (mask[1]) write_reg(REG_POINTS_V, draw_extent());
      if (mask[2]) write_reg(REG_POINTS_W, draw_extent());
      sender_eager   = ($urandom_range(0, 3) == 0);
      receiver_eager = ($urandom_range(0, 3) == 0);
      // one long receiver stall while items keep coming
      if (!held_once && n_sent > 250) begin
        held_once      = 1'b1;
        long_hold_req  = 1'b1;
        sender_eager   = 1'b1;
        receiver_eager = 1'b0;
      end
      phase_len = $urandom_range(30, 100);
      for (k = 0; k < phase_len && n_sent < ITEMS; k++) begin
        if ($urandom_range(0, 9) < 2)
          send_random_load();
        else
          send_random_point();
      end
    end

    drain();
    sb.flag_leftover();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
